### design/ecmc_pkg.sv
// Shared types, constants and register codes of the elevator car motion controller.
`timescale 1ns / 1ps
package ecmc_pkg;

  localparam int FLOOR_HEIGHT = 4800;
  localparam int STACK_DEPTH  = 16;
  localparam int NUM_FLOORS   = 32;
  localparam int SCHED_DEPTH  = 4;

  localparam int POS_W     = 18;
  localparam int VEL_W     = 11;
  localparam int ACC_W     = 9;
  localparam int FLOOR_W   = 5;
  localparam int TICK_W    = 32;
  localparam int VMAX_W    = 10;
  localparam int AMAX_W    = 8;
  localparam int DELAY_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;
  localparam int IN_DAT_W  = 8;
  localparam int OUT_DAT_W = 48;

  localparam int STK_IDX_W = $clog2(STACK_DEPTH);
  localparam int STK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SCH_IDX_W = $clog2(SCHED_DEPTH);
  localparam int SCH_CNT_W = $clog2(SCHED_DEPTH + 1);

  localparam int FH_LOG    = $clog2(FLOOR_HEIGHT);
  localparam int FH_W      = $clog2(FLOOR_HEIGHT + 1);
  localparam int REM_W     = FH_W;
  localparam int QUO_W     = POS_W - FH_LOG + 1;
  localparam int RECIP_SH  = POS_W + FH_LOG;
  localparam int RECIP_W   = POS_W + 2;
  localparam int PROD_W    = POS_W + RECIP_W;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SH) + FLOOR_HEIGHT - 1) / FLOOR_HEIGHT;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  localparam int TGT_W     = FLOOR_W + FH_W;
  localparam int DIV_W     = (TGT_W > POS_W) ? TGT_W : POS_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int VMAX_RST  = 120;
  localparam int AMAX_RST  = 4;
  localparam int MAXH_RST  = 72000;
  localparam int DELAY_RST = 70;
  localparam int RAMP_RST  = VMAX_RST / AMAX_RST;
  localparam int SD_RST    = VMAX_RST * RAMP_RST - (AMAX_RST * RAMP_RST * RAMP_RST) / 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_DLY  = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_TRIP, S_DIVC_GO, S_DIVC_WAIT, S_SCHED, S_APPLY, S_VEL, S_POS,
    S_FL1, S_FL2, S_EMIT, S_DIVR_GO, S_DIVR_WAIT, S_RAMP, S_MUL1, S_MUL2, S_SDFIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_PUSH, OP_DOOR, OP_CFG, OP_TRIP, OP_SCHED, OP_APPLY, OP_VEL,
    OP_POS, OP_FL1, OP_FL2, OP_EMIT, OP_RAMP, OP_MUL1, OP_MUL2, OP_SDFIN
  } op_e;

  typedef enum logic {
    DIV_RAMP,
    DIV_CRUISE
  } div_sel_e;

  typedef struct packed {
    op_e      op;
    logic     div_start;
    div_sel_e div_sel;
  } cmd_t;

  typedef struct packed {
    logic is_req;
    logic trip_go;
    logic cruise_go;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### design/ecmc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ecmc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ecmc_pkg::DIV_W-1:0]  dividend_i,
  input  logic [ecmc_pkg::VMAX_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [ecmc_pkg::DIV_W-1:0]  quotient_o
);
  import ecmc_pkg::*;

  logic [DIV_W-1:0]     quo_q;
  logic [VMAX_W-1:0]    rem_q;
  logic [VMAX_W-1:0]    dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [VMAX_W:0]      shifted;
  logic [VMAX_W:0]      diff;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[VMAX_W-1:0] : shifted[VMAX_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/ecmc_datapath.sv
// Datapath: car state, floor stack, acceleration schedule, profile math, result register.
`timescale 1ns / 1ps
module ecmc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ecmc_pkg::cmd_t                 cmd_i,
  output ecmc_pkg::status_t              st_o,
  input  logic [ecmc_pkg::IN_DAT_W-1:0]  in_tdata_i,
  input  logic                           in_tuser_i,
  input  logic [ecmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ecmc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           out_tready_i,
  output logic                           out_tvalid_o,
  output logic [ecmc_pkg::OUT_DAT_W-1:0] out_tdata_o
);
  import ecmc_pkg::*;

  // configuration and derived profile
  logic [VMAX_W-1:0]  vmax_q;
  logic [AMAX_W-1:0]  amax_q;
  logic [POS_W-1:0]   minh_q, maxh_q;
  logic [DELAY_W-1:0] delay_q;
  logic [VMAX_W-1:0]  ramp_q;
  logic [POS_W-1:0]   sd_q;
  logic [VMAX_W+VMAX_W-1:0] p1_q;
  logic [POS_W-1:0]   p2_q;
  logic [POS_W+VMAX_W-1:0]  p3_q;
  logic [POS_W+VMAX_W:0]    sd_full;

  // car state
  logic [POS_W-1:0]        pos_q;
  logic signed [VEL_W-1:0] vel_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [TICK_W-1:0]       tick_q;
  logic                    armed_q;
  logic [TICK_W-1:0]       deadline_q;
  logic [FLOOR_W-1:0]      stk_q [STACK_DEPTH];
  logic [STK_CNT_W-1:0]    stk_cnt_q;
  logic [TICK_W-1:0]       sch_when_q [SCHED_DEPTH];
  logic signed [ACC_W-1:0] sch_acc_q [SCHED_DEPTH];
  logic [SCH_CNT_W-1:0]    sch_cnt_q;
  logic [QUO_W-1:0]        q_q;
  logic [REM_W-1:0]        rem_q;
  logic                    dropped_q;

  // trip scratch
  logic [FLOOR_W-1:0] next_q;
  logic               up_q;
  logic [DIV_W-1:0]   slack_q;
  logic               cruise_en_q;
  logic [PROD_W-1:0]  prod_q;

  logic                 out_valid_q;
  logic [OUT_DAT_W-1:0] out_data_q;

  // divider
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_dvd;
  logic [VMAX_W-1:0] div_dvs;

  assign div_dvd = (cmd_i.div_sel == DIV_CRUISE) ? slack_q : DIV_W'(vmax_q);
  assign div_dvs = (cmd_i.div_sel == DIV_CRUISE) ? vmax_q : VMAX_W'(amax_q);

  ecmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // door and stack
  logic [STK_IDX_W-1:0] top_idx;
  logic [FLOOR_W-1:0]   top_floor;
  logic                 at_floor, door_fire, trip_go;
  logic [FLOOR_W-1:0]   req_floor;
  logic                 drop;

  assign top_idx   = STK_IDX_W'(stk_cnt_q - 1'b1);
  assign top_floor = stk_q[top_idx];
  assign at_floor  = (vel_q == '0) && (rem_q == '0) && (stk_cnt_q != '0);
  assign door_fire = at_floor && armed_q && (deadline_q < tick_q);
  assign trip_go   = door_fire && (32'(q_q) != 32'(top_floor));
  assign req_floor = in_tdata_i[FLOOR_W-1:0];
  assign drop      = (stk_cnt_q >= STK_CNT_W'(STACK_DEPTH)) ||
                     (32'(req_floor) >= NUM_FLOORS);

  // trip distance
  logic [TGT_W-1:0]  target;
  logic [DIV_W:0]    tgt_x, pos_x, trip_dist;
  logic [DIV_W+1:0]  two_sd;
  logic              up;

  assign target    = TGT_W'(next_q) * TGT_W'(FLOOR_HEIGHT);
  assign tgt_x     = (DIV_W+1)'(target);
  assign pos_x     = (DIV_W+1)'(pos_q);
  assign up        = pos_x < tgt_x;
  assign trip_dist = up ? (tgt_x - pos_x) : (pos_x - tgt_x);
  assign two_sd    = (DIV_W+2)'({sd_q, 1'b0});

  // schedule
  logic [DIV_W-1:0]        cruise;
  logic signed [ACC_W-1:0] a_pos, a_neg;
  assign cruise = cruise_en_q ? div_quo : '0;
  assign a_pos  = $signed({1'b0, amax_q});
  assign a_neg  = -a_pos;

  logic [SCH_IDX_W-1:0] sch_idx;
  logic                 sch_hit;
  assign sch_idx = SCH_IDX_W'(sch_cnt_q - 1'b1);
  assign sch_hit = (sch_cnt_q != '0) && (sch_when_q[sch_idx] == tick_q);

  // integration
  logic signed [VEL_W:0]   vsum, vlim, vnew;
  logic signed [POS_W+1:0] psum, pmax, pmin, pclamp, pnew;
  assign vsum = {vel_q[VEL_W-1], vel_q} + (VEL_W+1)'(acc_q);
  assign vlim = $signed({2'b00, vmax_q});
  always_comb begin
    vnew = vsum;
    if (vsum > vlim) vnew = vlim;
    if (vsum < -vlim) vnew = -vlim;
  end
  assign psum   = $signed({2'b00, pos_q}) + (POS_W+2)'(vel_q);
  assign pmax   = $signed({2'b00, maxh_q});
  assign pmin   = $signed({2'b00, minh_q});
  assign pclamp = (psum > pmax) ? pmax : psum;
  assign pnew   = (pclamp < pmin) ? pmin : pclamp;

  // floor of position by reciprocal multiply, exact for every position
  logic [QUO_W-1:0] q_new;
  logic [POS_W-1:0] qf;
  assign q_new = QUO_W'(prod_q >> RECIP_SH);
  assign qf    = POS_W'((POS_W+QUO_W)'(q_new) * (POS_W+QUO_W)'(FLOOR_HEIGHT));

  // result fields
  logic [REM_W:0]     dstop;
  logic               can_stop;
  logic [FLOOR_W-1:0] cur_floor;
  assign dstop    = (vel_q > 0) ? ((REM_W+1)'(FLOOR_HEIGHT) - (REM_W+1)'(rem_q))
                                : ((REM_W+1)'(rem_q) + (REM_W+1)'(FLOOR_HEIGHT));
  assign can_stop = (acc_q != '0) && (32'(dstop) <= 32'(sd_q));
  assign cur_floor = (32'(q_q) > 31) ? 5'd31 : FLOOR_W'(q_q);

  assign sd_full = (POS_W+VMAX_W+1)'(p1_q) - (POS_W+VMAX_W+1)'(p3_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmax_q      <= VMAX_W'(VMAX_RST);
      amax_q      <= AMAX_W'(AMAX_RST);
      minh_q      <= '0;
      maxh_q      <= POS_W'(MAXH_RST);
      delay_q     <= DELAY_W'(DELAY_RST);
      ramp_q      <= VMAX_W'(RAMP_RST);
      sd_q        <= POS_W'(SD_RST);
      pos_q       <= '0;
      vel_q       <= '0;
      acc_q       <= '0;
      tick_q      <= '0;
      armed_q     <= 1'b0;
      deadline_q  <= '0;
      stk_cnt_q   <= '0;
      sch_cnt_q   <= '0;
      q_q         <= '0;
      rem_q       <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CFG: begin
          case (cfg_index_i)
            CFG_MAX_VEL:  vmax_q  <= cfg_data_i[VMAX_W-1:0];
            CFG_MAX_ACC:  amax_q  <= cfg_data_i[AMAX_W-1:0];
            CFG_MIN_H:    minh_q  <= cfg_data_i[POS_W-1:0];
            CFG_MAX_H:    maxh_q  <= cfg_data_i[POS_W-1:0];
            CFG_DOOR_DLY: delay_q <= cfg_data_i[DELAY_W-1:0];
            default: ;
          endcase
        end
        OP_RAMP: ramp_q <= (amax_q == '0) ? '0 : VMAX_W'(div_quo);
        OP_SDFIN: sd_q <= (sd_full > (POS_W+VMAX_W+1)'({POS_W{1'b1}})) ?
                          {POS_W{1'b1}} : sd_full[POS_W-1:0];
        OP_PUSH: begin
          dropped_q <= drop;
          if (!drop) stk_cnt_q <= stk_cnt_q + 1'b1;
        end
        OP_DOOR: begin
          dropped_q <= 1'b0;
          if (at_floor) begin
            if (!armed_q) begin
              armed_q    <= 1'b1;
              deadline_q <= tick_q + TICK_W'(delay_q);
            end else if (door_fire) begin
              armed_q   <= 1'b0;
              stk_cnt_q <= stk_cnt_q - 1'b1;
            end
          end
        end
        OP_SCHED: sch_cnt_q <= SCH_CNT_W'(SCHED_DEPTH);
        OP_APPLY: begin
          if (sch_hit) begin
            sch_cnt_q <= sch_cnt_q - 1'b1;
            acc_q     <= sch_acc_q[sch_idx];
          end
        end
        OP_VEL: vel_q <= vnew[VEL_W-1:0];
        OP_POS: begin
          pos_q  <= pnew[POS_W-1:0];
          tick_q <= tick_q + 1'b1;
        end
        OP_FL2: begin
          q_q   <= q_new;
          rem_q <= REM_W'(pos_q - qf);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_PUSH: if (!drop) stk_q[STK_IDX_W'(stk_cnt_q)] <= req_floor;
      OP_DOOR: next_q <= top_floor;
      OP_TRIP: begin
        up_q        <= up;
        slack_q     <= DIV_W'(trip_dist - two_sd[DIV_W:0]);
        cruise_en_q <= ((DIV_W+2)'(trip_dist) > two_sd) && (vmax_q != '0);
      end
      OP_SCHED: begin
        // bottom entry is the last change, top entry applies right away
        sch_when_q[0] <= tick_q + (TICK_W'(ramp_q) << 1) + TICK_W'(cruise);
        sch_acc_q[0]  <= '0;
        sch_when_q[1] <= tick_q + TICK_W'(ramp_q) + TICK_W'(cruise);
        sch_acc_q[1]  <= up_q ? a_neg : a_pos;
        sch_when_q[2] <= tick_q + TICK_W'(ramp_q);
        sch_acc_q[2]  <= '0;
        sch_when_q[3] <= tick_q;
        sch_acc_q[3]  <= up_q ? a_pos : a_neg;
      end
      OP_MUL1: begin
        p1_q <= (VMAX_W+VMAX_W)'(vmax_q) * (VMAX_W+VMAX_W)'(ramp_q);
        p2_q <= POS_W'((AMAX_W+VMAX_W)'(amax_q) * (AMAX_W+VMAX_W)'(ramp_q));
      end
      OP_MUL2: p3_q <= (POS_W+VMAX_W)'(p2_q) * (POS_W+VMAX_W)'(ramp_q);
      OP_FL1: prod_q <= PROD_W'(pos_q) * PROD_W'(RECIP);
      OP_EMIT: out_data_q <= {2'b00, dropped_q, can_stop, armed_q, cur_floor,
                              acc_q, vel_q, pos_q};
      default: ;
    endcase
  end

  assign st_o.is_req    = in_tuser_i;
  assign st_o.trip_go   = trip_go;
  assign st_o.cruise_go = cruise_en_q;
  assign st_o.div_done  = div_done;
  assign st_o.out_free  = !out_valid_q || out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cnt_q <= STK_CNT_W'(STACK_DEPTH)) else $error("floor stack overflow");
  a_sched_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sch_cnt_q <= SCH_CNT_W'(SCHED_DEPTH)) else $error("schedule overflow");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rem_q) < FLOOR_HEIGHT) else $error("floor remainder out of range");
  a_pop_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DOOR && door_fire) |=> !armed_q) else $error("door stays armed");

endmodule

### design/ecmc_ctrl.sv
// Controller: sequences item handling, departure planning and profile derivation.
`timescale 1ns / 1ps
module ecmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_tvalid_i,
  output logic              in_tready_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  ecmc_pkg::status_t st_i,
  output ecmc_pkg::cmd_t    cmd_o
);
  import ecmc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o.op          = OP_NONE;
    cmd_o.div_start   = 1'b0;
    cmd_o.div_sel     = DIV_RAMP;
    in_tready_o       = 1'b0;
    cfg_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        in_tready_o = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.op = OP_CFG;
          state_d  = S_DIVR_GO;
        end else if (in_tvalid_i) begin
          if (st_i.is_req) begin
            cmd_o.op = OP_PUSH;
            state_d  = S_EMIT;
          end else begin
            cmd_o.op = OP_DOOR;
            state_d  = st_i.trip_go ? S_TRIP : S_APPLY;
          end
        end
      end
      S_TRIP: begin
        cmd_o.op = OP_TRIP;
        state_d  = S_DIVC_GO;
      end
      S_DIVC_GO: begin
        if (st_i.cruise_go) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_CRUISE;
          state_d         = S_DIVC_WAIT;
        end else begin
          state_d = S_SCHED;
        end
      end
      S_DIVC_WAIT: begin
        cmd_o.div_sel = DIV_CRUISE;
        if (st_i.div_done) state_d = S_SCHED;
      end
      S_SCHED: begin
        cmd_o.op      = OP_SCHED;
        cmd_o.div_sel = DIV_CRUISE;
        state_d       = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.op = OP_APPLY;
        state_d  = S_VEL;
      end
      S_VEL: begin
        cmd_o.op = OP_VEL;
        state_d  = S_POS;
      end
      S_POS: begin
        cmd_o.op = OP_POS;
        state_d  = S_FL1;
      end
      S_FL1: begin
        cmd_o.op = OP_FL1;
        state_d  = S_FL2;
      end
      S_FL2: begin
        cmd_o.op = OP_FL2;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register frees up
        if (st_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      S_DIVR_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVR_WAIT;
      end
      S_DIVR_WAIT: begin
        if (st_i.div_done) state_d = S_RAMP;
      end
      S_RAMP: begin
        cmd_o.op = OP_RAMP;
        state_d  = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = S_SDFIN;
      end
      S_SDFIN: begin
        cmd_o.op = OP_SDFIN;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/elevator_car_motion_controller_core.sv
// Top level of the elevator car motion controller: controller plus datapath.
//
// Input stream (s_axis_*): one transfer per item. tuser is the item kind
// (0 = time tick, 1 = floor request), tdata carries the requested floor.
// Output stream (m_axis_*): exactly one result transfer per accepted item,
// in order, holding the car state after that item.
// Config channel (cfg_*): register index and data; write only while idle.
//
// Sequencing: a floor request is pushed on acceptance, then its result is
// emitted. A tick steps through the APPLY, VEL, POS, FL1 and FL2 states
// before its result is emitted. A tick that starts a trip first passes the
// TRIP state, and when a cruise phase is divided out it also waits for the
// shared serial divider to deliver its 18-bit quotient before SCHED. Every
// result waits in EMIT while the result register is not free. One item is
// handled at a time: the next is not accepted until the last is emitted.
// A configuration write keeps both channels blocked while the ramp time is
// derived on the same divider and the stop distance by multiplies.
// Reset (rst_ni low) returns registers to their power-on values and the car
// to rest at height zero. A stalled receiver holds the result register; the
// next item may be accepted and processed, then waits to be emitted.
`timescale 1ns / 1ps
module elevator_car_motion_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ecmc_pkg::IN_DAT_W-1:0]  s_axis_tdata,  // [4:0] floor, [7:5] zero
  input  logic                           s_axis_tuser,  // [0] req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [17:0] position, [28:18] velocity, [37:29] acceleration, [42:38] current_floor,
  // [43] door_waiting, [44] can_stop_next, [45] request_dropped, [47:46] zero
  output logic [ecmc_pkg::OUT_DAT_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ecmc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ecmc_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import ecmc_pkg::*;

  cmd_t    cmd;
  status_t st;

  ecmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  ecmc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

### verif/tb_elevator_car_motion_controller_core.sv
// Self-checking testbench of the elevator car motion controller core.
`timescale 1ns / 1ps
module tb_elevator_car_motion_controller_core;
  import ecmc_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [VEL_W-1:0]   velocity;
    logic [ACC_W-1:0]   acceleration;
    logic [FLOOR_W-1:0] current_floor;
    logic               door_waiting;
    logic               can_stop_next;
    logic               request_dropped;
  } car_state_t;

  // Predicts the car state after each item and checks the result stream in order.
  class car_scoreboard;
    longint unsigned vmax, amax, hmin, hmax, ddelay;
    longint      pos;
    longint      vel, acc;
    bit [31:0]   ticks;
    bit          armed;
    bit [31:0]   deadline;
    int          stack[STACK_DEPTH];
    int          stack_cnt;
    bit [31:0]   sched_when[SCHED_DEPTH];
    longint      sched_acc[SCHED_DEPTH];
    int          sched_cnt;
    longint unsigned ramp, stop_dist;
    car_state_t  pending[$];
    int          errors;
    int          checked;

    function new();
      vmax = VMAX_RST; amax = AMAX_RST; hmin = 0; hmax = MAXH_RST; ddelay = DELAY_RST;
      pos = 0; vel = 0; acc = 0; ticks = 0; armed = 0; deadline = 0;
      stack_cnt = 0; sched_cnt = 0; errors = 0; checked = 0;
      derive();
    endfunction

    function void derive();
      longint unsigned sd;
      ramp = (amax == 0) ? 0 : vmax / amax;
      sd = vmax * ramp - (amax * ramp * ramp) / 2;
      stop_dist = (sd > 262143) ? 262143 : sd;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
      case (idx)
        CFG_MAX_VEL:  vmax = val & 10'h3ff;
        CFG_MAX_ACC:  amax = val & 8'hff;
        CFG_MIN_H:    hmin = val & 18'h3ffff;
        CFG_MAX_H:    hmax = val & 18'h3ffff;
        CFG_DOOR_DLY: ddelay = val & 10'h3ff;
        default: return;
      endcase
      derive();
    endfunction

    function void plan_trip(int dest);
      longint target, trip_dist, slack;
      longint unsigned cruise;
      bit up;
      target = longint'(dest) * FLOOR_HEIGHT;
      trip_dist = pos - target;
      up = pos < target;
      cruise = 0;
      if (trip_dist < 0) trip_dist = -trip_dist;
      slack = trip_dist - 2 * longint'(stop_dist);
      if (slack > 0 && vmax != 0) cruise = slack / longint'(vmax);
      sched_when[0] = ticks + 32'(2 * ramp) + 32'(cruise);
      sched_acc[0] = 0;
      sched_when[1] = ticks + 32'(ramp) + 32'(cruise);
      sched_acc[1] = up ? -longint'(amax) : longint'(amax);
      sched_when[2] = ticks + 32'(ramp);
      sched_acc[2] = 0;
      sched_when[3] = ticks;
      sched_acc[3] = up ? longint'(amax) : -longint'(amax);
      sched_cnt = SCHED_DEPTH;
    endfunction

    function void advance_time();
      int here, dest;
      if (vel == 0 && pos % FLOOR_HEIGHT == 0 && stack_cnt > 0) begin
        if (!armed) begin
          armed = 1;
          deadline = ticks + 32'(ddelay);
        end else if (deadline < ticks) begin
          here = pos / FLOOR_HEIGHT;
          armed = 0;
          stack_cnt--;
          dest = stack[stack_cnt];
          if (here != dest) plan_trip(dest);
        end
      end
      if (sched_cnt > 0 && sched_when[sched_cnt-1] == ticks) begin
        sched_cnt--;
        acc = sched_acc[sched_cnt];
      end
      vel += acc;
      if (vel > longint'(vmax)) vel = vmax;
      if (vel < -longint'(vmax)) vel = -longint'(vmax);
      pos += vel;
      if (pos > longint'(hmax)) pos = hmax;
      if (pos < longint'(hmin)) pos = hmin;
      ticks++;
    endfunction

    function void note_item(bit is_req, int flr);
      car_state_t s;
      longint cf, nf, d;
      s.request_dropped = 0;
      if (is_req) begin
        if (stack_cnt >= STACK_DEPTH || flr >= NUM_FLOORS) s.request_dropped = 1;
        else stack[stack_cnt++] = flr;
      end else begin
        advance_time();
      end
      cf = pos / FLOOR_HEIGHT;
      if (cf > 31) cf = 31;
      s.position = POS_W'(pos);
      s.velocity = VEL_W'(vel);
      s.acceleration = ACC_W'(acc);
      s.current_floor = FLOOR_W'(cf);
      s.door_waiting = armed;
      s.can_stop_next = 0;
      if (acc != 0) begin
        nf = pos / FLOOR_HEIGHT + ((vel > 0) ? 1 : -1);
        d = nf * FLOOR_HEIGHT - pos;
        if (d < 0) d = -d;
        s.can_stop_next = d <= longint'(stop_dist);
      end
      pending = {pending, s};
    endfunction

    function void check_result(logic [OUT_DAT_W-1:0] data);
      car_state_t got, exp_s;
      got = {data[17:0], data[28:18], data[37:29], data[42:38], data[43], data[44], data[45]};
      if (pending.size() == 0) begin
        $error("result with no item outstanding: %h", data);
        errors++;
        return;
      end
      exp_s = pending.pop_front();
      checked++;
      if (got.position != exp_s.position) begin
        $error("position exp %0d got %0d", exp_s.position, got.position); errors++;
      end
      if (got.velocity != exp_s.velocity) begin
        $error("velocity exp %0d got %0d", $signed(exp_s.velocity), $signed(got.velocity));
        errors++;
      end
      if (got.acceleration != exp_s.acceleration) begin
        $error("acceleration exp %0d got %0d", $signed(exp_s.acceleration),
               $signed(got.acceleration));
        errors++;
      end
      if (got.current_floor != exp_s.current_floor) begin
        $error("current_floor exp %0d got %0d", exp_s.current_floor, got.current_floor);
        errors++;
      end
      if (got.door_waiting != exp_s.door_waiting) begin
        $error("door_waiting exp %0d got %0d", exp_s.door_waiting, got.door_waiting); errors++;
      end
      if (got.can_stop_next != exp_s.can_stop_next) begin
        $error("can_stop_next exp %0d got %0d", exp_s.can_stop_next, got.can_stop_next);
        errors++;
      end
      if (got.request_dropped != exp_s.request_dropped) begin
        $error("request_dropped exp %0d got %0d", exp_s.request_dropped,
               got.request_dropped);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [IN_DAT_W-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tuser = 0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [OUT_DAT_W-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  car_scoreboard sb = new();
  bit quiet = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int reqs_sent = 0;

  always #2 clk_i = ~clk_i;

  elevator_car_motion_controller_core u_dut (.*);

  // Receiver: random stall bursts, none once quiet is set.
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10);
        m_axis_tready <= 0;
        repeat (burst) @(posedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // Hold tvalid across back-to-back items; drop it only for an idle burst.
  task automatic send_item(bit is_req, logic [4:0] flr);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= is_req;
    s_axis_tdata <= {3'b000, flr};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(is_req, flr);
    items_sent++;
    if (is_req) reqs_sent++; else ticks_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic set_profile(int vm, int am, int lo, int hi, int dly);
    drain();
    write_reg(CFG_MAX_VEL, vm);
    write_reg(CFG_MAX_ACC, am);
    write_reg(CFG_MIN_H, lo);
    write_reg(CFG_MAX_H, hi);
    write_reg(CFG_DOOR_DLY, dly);
    cfg_valid_i <= 0;
  endtask

  // Mostly ticks so trips complete; a few requests to keep the stack busy.
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) send_item(1, 5'($urandom_range(0, 31)));
      else send_item(0, 5'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: extreme floors, ticks with bits set in floor, stack overflow.
    send_item(1, 5'd31);
    send_item(1, 5'd0);
    send_item(0, 5'd31);
    for (int i = 0; i < 15; i++) send_item(1, 5'(i + 1));
    send_item(1, 5'd7);
    drain();
    // Short delay and high limits: trips with cruise phases.
    set_profile(120, 4, 0, 262143, 0);
    random_phase(150);
    // Slow car, inverted limits, long door delay.
    set_profile(12, 3, 9600, 4800, 1023);
    random_phase(60);
    // Extremes: zero acceleration and velocity, then largest values.
    set_profile(0, 0, 0, 72000, 1);
    random_phase(40);
    set_profile(1023, 255, 0, 262143, 2);
    random_phase(120);
    set_profile(1020, 1, 262143, 262143, 5);
    random_phase(40);
    set_profile(40, 8, 0, 100000, 3);
    random_phase(150);
    drain();
    quiet = 1;
    random_phase(140);
    drain();
    $display("Covered %0d items (%0d ticks, %0d floor requests), %0d results checked,",
             items_sent, ticks_sent, reqs_sent, sb.checked);
    $display("across six register settings including zero and full-scale limits.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
design/ecmc_pkg.sv
design/ecmc_div.sv
design/ecmc_datapath.sv
design/ecmc_ctrl.sv
design/elevator_car_motion_controller_core.sv
verif/tb_elevator_car_motion_controller_core.sv
